/* rtl/min_queue_two_stacks_unit_defines.svh */
// Assertion macros shared by the min queue RTL.
`ifndef MIN_QUEUE_TWO_STACKS_UNIT_DEFINES_SVH
`define MIN_QUEUE_TWO_STACKS_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MQTS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define MQTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/mqts_pkg.sv */
// Package with the types and constants of the min queue.
package mqts_pkg;

  // Queue sizing.
  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int ENTRY_W  = 2 * DATA_W;
  localparam int COUNT_W  = 11;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 48;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 3'd0,
    CMD_DEQUEUE = 3'd1,
    CMD_FRONT   = 3'd2,
    CMD_MIN     = 3'd3,
    CMD_SIZE    = 3'd4,
    CMD_CLEAR   = 3'd5
  } cmd_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_DECODE,
    SEQ_MOVE_RD,
    SEQ_MOVE_WR,
    SEQ_RELOAD_RD,
    SEQ_RELOAD_WR
  } seq_state_e;

endpackage

/* rtl/mqts_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module mqts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/min_queue_two_stacks_unit.sv */
// Top level of the min queue built from two running-minimum stacks.
// A FIFO of signed 32-bit values that also reports its minimum. Each stack keeps its
// entries in a RAM of value and running minimum. The input stack's top minimum and the
// output stack's top value and minimum are held in registers. The result of a command
// is registered from the decode state that follows its input transfer, and no new input
// transfer is taken until the sequencer is back in idle. A dequeue that leaves at least
// one entry on the output stack then reloads the new top from its RAM in the reload read
// and reload write states. If the result register is still waiting on the output side,
// the command waits in its decode state until that register frees up. When a dequeue or
// front finds the output stack empty on a nonempty queue, the whole input stack is moved
// first, each entry through a move read and a move write state, as the input-stack RAM
// has a registered read port. One signed minimum unit serves enqueue, the move loop and
// the min command. No clearing pass is needed after reset.
`include "min_queue_two_stacks_unit_defines.svh"

module min_queue_two_stacks_unit import mqts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Fields from bit 0 up: cmd [2:0], value [34:3], zero pad.
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // Fields from bit 0 up: status [1:0], data [33:2], count [44:34], zero pad.
  output logic [OUT_W-1:0] m_axis_tdata_o,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i
);

  seq_state_e state_q, state_d;

  logic [CMD_W-1:0]  cmd_q;
  logic [DATA_W-1:0] value_q;

  logic [CNT_W-1:0]  in_cnt_q, in_cnt_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;
  logic [DATA_W-1:0] in_top_min_q, in_top_min_d;
  logic [DATA_W-1:0] out_top_val_q, out_top_val_d;
  logic [DATA_W-1:0] out_top_min_q, out_top_min_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [DATA_W-1:0]   data_q, data_d;
  logic [COUNT_W-1:0]  count_q, count_d;

  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] in_cnt_m1;
  logic [CNT_W-1:0] out_cnt_m1;
  logic             slot_free;
  logic             need_move;
  logic             do_exec;

  logic signed [DATA_W-1:0] min_a, min_b, min_y;

  logic                in_we;
  logic [ENTRY_W-1:0]  in_wdata, in_rdata;
  logic                out_we;
  logic [ENTRY_W-1:0]  out_wdata, out_rdata;
  logic [DATA_W-1:0]   move_val;

  assign total      = in_cnt_q + out_cnt_q;
  assign in_cnt_m1  = in_cnt_q - 1'b1;
  assign out_cnt_m1 = out_cnt_q - 1'b1;
  assign slot_free  = !out_valid_q || m_axis_tready_i;
  assign move_val   = in_rdata[DATA_W-1:0];

  // A dequeue or front on a nonempty queue with an empty output stack moves first.
  assign need_move = (cmd_q inside {CMD_DEQUEUE, CMD_FRONT}) &&
                     (total != '0) && (out_cnt_q == '0);
  assign do_exec   = (state_q == SEQ_DECODE) && !need_move && slot_free;

  // Shared signed minimum unit; operands depend on the step in progress.
  always_comb begin
    min_a = in_top_min_q;
    min_b = value_q;
    if (state_q == SEQ_MOVE_WR) begin
      min_a = out_top_min_q;
      min_b = move_val;
    end else if (cmd_q == CMD_MIN) begin
      min_a = in_top_min_q;
      min_b = out_top_min_q;
    end
  end

  assign min_y = (min_b < min_a) ? min_b : min_a;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      SEQ_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = SEQ_DECODE;
        end
      end
      SEQ_DECODE: begin
        if (need_move) begin
          state_d = SEQ_MOVE_RD;
        end else if (slot_free) begin
          if ((cmd_q == CMD_DEQUEUE) && (total != '0) && (out_cnt_q > CNT_W'(1))) begin
            state_d = SEQ_RELOAD_RD;
          end else begin
            state_d = SEQ_IDLE;
          end
        end
      end
      SEQ_MOVE_RD:   state_d = SEQ_MOVE_WR;
      SEQ_MOVE_WR:   state_d = (in_cnt_q == '0) ? SEQ_DECODE : SEQ_MOVE_RD;
      SEQ_RELOAD_RD: state_d = SEQ_RELOAD_WR;
      SEQ_RELOAD_WR: state_d = SEQ_IDLE;
      default:       state_d = SEQ_IDLE;
    endcase
  end

  // Datapath and result logic.
  always_comb begin
    in_cnt_d      = in_cnt_q;
    out_cnt_d     = out_cnt_q;
    in_top_min_d  = in_top_min_q;
    out_top_val_d = out_top_val_q;
    out_top_min_d = out_top_min_q;
    in_we         = 1'b0;
    in_wdata      = {min_y, value_q};
    out_we        = 1'b0;
    out_wdata     = {min_y, move_val};
    status_d      = status_q;
    data_d        = data_q;
    out_valid_d   = out_valid_q && !m_axis_tready_i;

    case (state_q)
      SEQ_DECODE: begin
        if (do_exec) begin
          status_d    = ST_OK;
          data_d      = '0;
          out_valid_d = 1'b1;
          case (cmd_q)
            CMD_ENQUEUE: begin
              if (total == CAP_CNT) begin
                status_d = ST_FULL;
              end else begin
                in_we        = 1'b1;
                in_wdata     = (in_cnt_q == '0) ? {value_q, value_q} : {min_y, value_q};
                in_top_min_d = in_wdata[ENTRY_W-1:DATA_W];
                in_cnt_d     = in_cnt_q + 1'b1;
              end
            end
            CMD_DEQUEUE, CMD_FRONT: begin
              if (total == '0) begin
                status_d = ST_EMPTY;
              end else begin
                data_d = out_top_val_q;
                if (cmd_q == CMD_DEQUEUE) begin
                  out_cnt_d = out_cnt_m1;
                end
              end
            end
            CMD_MIN: begin
              if (total == '0) begin
                status_d = ST_EMPTY;
              end else if (in_cnt_q == '0) begin
                data_d = out_top_min_q;
              end else if (out_cnt_q == '0) begin
                data_d = in_top_min_q;
              end else begin
                data_d = min_y;
              end
            end
            CMD_CLEAR: begin
              in_cnt_d  = '0;
              out_cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      SEQ_MOVE_RD: begin
        in_cnt_d = in_cnt_m1;
      end
      SEQ_MOVE_WR: begin
        out_we        = 1'b1;
        out_wdata     = (out_cnt_q == '0) ? {move_val, move_val} : {min_y, move_val};
        out_top_val_d = move_val;
        out_top_min_d = out_wdata[ENTRY_W-1:DATA_W];
        out_cnt_d     = out_cnt_q + 1'b1;
      end
      SEQ_RELOAD_WR: begin
        out_top_val_d = out_rdata[DATA_W-1:0];
        out_top_min_d = out_rdata[ENTRY_W-1:DATA_W];
      end
      default: begin
      end
    endcase

    count_d = do_exec ? COUNT_W'(in_cnt_d + out_cnt_d) : count_q;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      in_cnt_q    <= '0;
      out_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_cnt_q    <= in_cnt_d;
      out_cnt_q   <= out_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      cmd_q   <= s_axis_tdata_i[CMD_W-1:0];
      value_q <= s_axis_tdata_i[CMD_W+DATA_W-1:CMD_W];
    end
    in_top_min_q  <= in_top_min_d;
    out_top_val_q <= out_top_val_d;
    out_top_min_q <= out_top_min_d;
    status_q      <= status_d;
    data_q        <= data_d;
    count_q       <= count_d;
  end

  // Input stack storage: running minimum in the upper half, value in the lower half.
  mqts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_in_ram (
    .clk_i   (clk_i),
    .we_i    (in_we),
    .waddr_i (in_cnt_q[ADDR_W-1:0]),
    .wdata_i (in_wdata),
    .raddr_i (in_cnt_m1[ADDR_W-1:0]),
    .rdata_o (in_rdata)
  );

  // Output stack storage, same layout.
  mqts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_out_ram (
    .clk_i   (clk_i),
    .we_i    (out_we),
    .waddr_i (out_cnt_q[ADDR_W-1:0]),
    .wdata_i (out_wdata),
    .raddr_i (out_cnt_m1[ADDR_W-1:0]),
    .rdata_o (out_rdata)
  );

  assign s_axis_tready_o = (state_q == SEQ_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_W - COUNT_W - DATA_W - STATUS_W)'(0),
                            count_q, data_q, status_q};

  // The queue never holds more than its capacity.
  `MQTS_ASSERT_SAME(a_total_bound, 1'b1, total <= CAP_CNT)
  // The move loop only runs while the input stack still holds entries.
  `MQTS_ASSERT_SAME(a_move_nonempty, state_q == SEQ_MOVE_RD, in_cnt_q != '0)
  // Each move write grows the output stack by exactly one entry.
  `MQTS_ASSERT_NEXT(a_move_grow, state_q == SEQ_MOVE_WR, out_cnt_q == $past(out_cnt_q) + 1'b1)
  // A top reload only happens when the output stack is not empty.
  `MQTS_ASSERT_SAME(a_reload_nonempty, state_q == SEQ_RELOAD_RD, out_cnt_q != '0)

endmodule

/* test/min_queue_checker.sv */
// Checker that predicts every result of the min queue and compares it with the block output.
module min_queue_checker import mqts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Fields from bit 0 up: cmd [2:0], value [34:3], zero pad.
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  input  logic             s_axis_tvalid_i,
  input  logic             s_axis_tready_i,
  // Fields from bit 0 up: status [1:0], data [33:2], count [44:34], zero pad.
  input  logic [OUT_W-1:0] m_axis_tdata_i,
  input  logic             m_axis_tvalid_i,
  input  logic             m_axis_tready_i,
  output int               pending_o,
  output int               error_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One result of a command as the block reports it.
  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] data;
    logic [COUNT_W-1:0]       count;
  } queue_reply_t;

  // Shadow copy of both running-minimum stacks.
  logic signed [DATA_W-1:0] in_vals  [CAPACITY];
  logic signed [DATA_W-1:0] in_mins  [CAPACITY];
  logic signed [DATA_W-1:0] out_vals [CAPACITY];
  logic signed [DATA_W-1:0] out_mins [CAPACITY];
  int in_depth  = 0;
  int out_depth = 0;

  queue_reply_t queued_replies [$];
  queue_reply_t want;
  int errors = 0;

  function automatic logic signed [DATA_W-1:0] smaller_of(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    return (b < a) ? b : a;
  endfunction

  // Move the whole input stack onto the output stack once the output stack runs dry.
  function automatic void refill_out_stack();
    logic signed [DATA_W-1:0] v;
    if (out_depth != 0) return;
    while (in_depth > 0) begin
      in_depth--;
      v = in_vals[in_depth];
      out_vals[out_depth] = v;
      if (out_depth == 0) begin
        out_mins[out_depth] = v;
      end else begin
        out_mins[out_depth] = smaller_of(out_mins[out_depth-1], v);
      end
      out_depth++;
    end
  endfunction

  // Update the shadow queue for one command and return the result it should give.
  function automatic queue_reply_t apply_command(
    input logic [CMD_W-1:0]       cmd,
    input logic signed [DATA_W-1:0] value
  );
    queue_reply_t r;
    int total;
    r.status = ST_OK;
    r.data   = '0;
    total    = in_depth + out_depth;
    case (cmd)
      CMD_ENQUEUE: begin
        if (total >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          in_vals[in_depth] = value;
          if (in_depth == 0) begin
            in_mins[in_depth] = value;
          end else begin
            in_mins[in_depth] = smaller_of(in_mins[in_depth-1], value);
          end
          in_depth++;
        end
      end
      CMD_DEQUEUE, CMD_FRONT: begin
        if (total == 0) begin
          r.status = ST_EMPTY;
        end else begin
          refill_out_stack();
          r.data = out_vals[out_depth-1];
          if (cmd == CMD_DEQUEUE) out_depth--;
        end
      end
      CMD_MIN: begin
        if (total == 0) begin
          r.status = ST_EMPTY;
        end else if (in_depth == 0) begin
          r.data = out_mins[out_depth-1];
        end else if (out_depth == 0) begin
          r.data = in_mins[in_depth-1];
        end else begin
          r.data = smaller_of(in_mins[in_depth-1], out_mins[out_depth-1]);
        end
      end
      CMD_CLEAR: begin
        in_depth  = 0;
        out_depth = 0;
      end
      default: begin
      end
    endcase
    r.count = COUNT_W'(in_depth + out_depth);
    return r;
  endfunction

  // Compare each output transfer first, then predict from each input transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (queued_replies.size() == 0) begin
          errors++;
          $display("%0t: result with no command waiting, expected none, actual %h",
                   $time, m_axis_tdata_i);
        end else begin
          want = queued_replies.pop_front();
          if (m_axis_tdata_i[1:0] !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, m_axis_tdata_i[1:0]);
          end
          if (m_axis_tdata_i[33:2] !== want.data) begin
            errors++;
            $display("%0t: data expected %0d actual %0d",
                     $time, want.data, $signed(m_axis_tdata_i[33:2]));
          end
          if (m_axis_tdata_i[44:34] !== want.count) begin
            errors++;
            $display("%0t: count expected %0d actual %0d",
                     $time, want.count, m_axis_tdata_i[44:34]);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        queued_replies.push_back(apply_command(s_axis_tdata_i[2:0], s_axis_tdata_i[34:3]));
      end
    end
    pending_o     <= queued_replies.size();
    error_count_o <= errors;
  end

endmodule

/* test/tb_min_queue_two_stacks_unit.sv */
// Testbench top for the min queue: drives commands, applies backpressure and reports the verdict.
module tb_min_queue_two_stacks_unit import mqts_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Command codes the block treats as no-ops.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam int IDLE_PCT     = 19;
  localparam int TAIL_CYCLES  = 16;
  localparam int LIMIT_CYCLES = 200000;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic [IN_W-1:0]  s_axis_tdata_i;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  logic [OUT_W-1:0] m_axis_tdata_o;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;

  logic no_idle;
  int   pending;
  int   error_count;
  int   cycle_count = 0;

  min_queue_two_stacks_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i)
  );

  min_queue_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .pending_o       (pending),
    .error_count_o   (error_count)
  );

  always #4 clk_i = ~clk_i;

  // Result side: random backpressure, none during the burst stretch.
  always @(posedge clk_i) begin
    m_axis_tready_i <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Mostly random patterns, with the extremes and a narrow band for ties.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return DATA_W'(int'($urandom_range(0, 32)) - 16);
      default: return $urandom();
    endcase
  endfunction

  // Enqueue with the given percentage, otherwise one of the other commands.
  function automatic logic [CMD_W-1:0] pick_cmd(input int enq_pct);
    int r;
    if ($urandom_range(0, 99) < enq_pct) return CMD_ENQUEUE;
    r = $urandom_range(0, 99);
    if (r < 45) return CMD_DEQUEUE;
    if (r < 60) return CMD_FRONT;
    if (r < 80) return CMD_MIN;
    if (r < 88) return CMD_SIZE;
    if (r < 93) return CMD_CLEAR;
    if (r < 97) return CMD_SPARE_LO;
    return CMD_SPARE_HI;
  endfunction

  // One command transfer, after an optional random gap.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_W'({value, cmd});
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic run_mixed(input int n, input int enq_pct);
    repeat (n) send_command(pick_cmd(enq_pct), pick_value());
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tvalid_i = 1'b0;
    no_idle         = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty-queue errors and size on an empty queue.
    send_command(CMD_DEQUEUE, 32'h0);
    send_command(CMD_FRONT, 32'hFFFF_FFFF);
    send_command(CMD_MIN, 32'h0);
    send_command(CMD_SIZE, 32'h0);
    // Extreme values, then ordering and minimum tracking while draining.
    send_command(CMD_ENQUEUE, 32'h7FFF_FFFF);
    send_command(CMD_ENQUEUE, 32'h8000_0000);
    send_command(CMD_ENQUEUE, 32'h0000_0000);
    send_command(CMD_ENQUEUE, 32'hFFFF_FFFF);
    send_command(CMD_MIN, 32'h0);
    send_command(CMD_FRONT, 32'h0);
    send_command(CMD_SIZE, 32'h0);
    send_command(CMD_DEQUEUE, 32'h0);
    send_command(CMD_MIN, 32'h0);
    send_command(CMD_DEQUEUE, 32'h0);
    send_command(CMD_MIN, 32'h0);
    // Spare codes change nothing.
    send_command(CMD_SPARE_LO, 32'hFFFF_FFFF);
    send_command(CMD_SPARE_HI, 32'h5555_AAAA);
    // Mixing a new entry in the input stack with a loaded output stack.
    send_command(CMD_ENQUEUE, 32'h0000_0005);
    send_command(CMD_MIN, 32'h0);
    send_command(CMD_DEQUEUE, 32'h0);
    send_command(CMD_FRONT, 32'h0);
    send_command(CMD_CLEAR, 32'h0);
    send_command(CMD_MIN, 32'h0);
    send_command(CMD_DEQUEUE, 32'h0);

    // Random commands on a short queue.
    run_mixed(300, 55);

    // Fill to capacity and push past it with no idling on either side.
    no_idle <= 1'b1;
    send_command(CMD_CLEAR, 32'h0);
    repeat (CAPACITY + 3) send_command(CMD_ENQUEUE, pick_value());
    send_command(CMD_MIN, 32'h0);
    send_command(CMD_DEQUEUE, 32'h0);
    send_command(CMD_ENQUEUE, pick_value());
    send_command(CMD_ENQUEUE, pick_value());
    no_idle <= 1'b0;

    // Random commands leaning toward removal.
    run_mixed(300, 20);

    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
